/* src/owm_pkg.sv */
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the 1-Wire bus master: word layouts,
// command codes, sequencer phases and timing register defaults.
// ----------------------------------------------------------------------------
package owm_pkg;

  // timing registers
  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 10;
  localparam int CFG_IDX_W = 4;
  localparam int CNT_W     = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 4'd7;

  // timing defaults in microseconds
  localparam logic [REG_W-1:0] DEF_RESET_LOW      = 10'd480;
  localparam logic [REG_W-1:0] DEF_PRESENCE_WAIT  = 10'd70;
  localparam logic [REG_W-1:0] DEF_RESET_TAIL     = 10'd410;
  localparam logic [REG_W-1:0] DEF_WRITE_ONE_LOW  = 10'd6;
  localparam logic [REG_W-1:0] DEF_WRITE_ZERO_LOW = 10'd60;
  localparam logic [REG_W-1:0] DEF_READ_LOW       = 10'd6;
  localparam logic [REG_W-1:0] DEF_READ_SAMPLE    = 10'd9;
  localparam logic [REG_W-1:0] DEF_SLOT           = 10'd70;

  // command codes
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // sequencer phases
  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_RST_LOW   = 6'b000010,
    PH_RST_WAIT  = 6'b000100,
    PH_RST_TAIL  = 6'b001000,
    PH_SLOT_LOW  = 6'b010000,
    PH_SLOT_HIGH = 6'b100000
  } phase_t;

  // input word
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] wr_byte;
    logic       line_in;
  } in_t;

  // result word
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rd_byte;
    logic       rejected;
  } out_t;

  // a zero length counts as one microsecond
  function automatic logic [REG_W-1:0] at_least_one(input logic [REG_W-1:0] v);
    return (v == '0) ? REG_W'(1) : v;
  endfunction

endpackage

/* src/one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master sequencing reset/presence, byte write and byte read slots.
// ----------------------------------------------------------------------------
// Every input word is one microsecond of bus time and yields exactly one result
// word carrying the bus drive, busy/done flags, the last presence result, the
// last read byte and a rejected flag for commands given while busy. A command
// starts on the word that carries it, which is already its first microsecond.
// The block takes one word per clock cycle: the timing sequencer's next state is
// combinational and its result goes into one output register, so a new word is
// accepted whenever that register is empty or being taken in the same cycle.
// The eight timing registers are written through the configuration port, which
// is always ready; indexes beyond the list are ignored.
module one_wire_bus_master (
  input  logic                          clk,
  input  logic                          rst,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  owm_pkg::in_t                  in_data,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output owm_pkg::out_t                 out_data,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::REG_W-1:0]     cfg_data
);

  localparam int RW = owm_pkg::REG_W;
  localparam int CW = owm_pkg::CNT_W;

  // timing registers
  logic [RW-1:0] reset_low_us, presence_wait_us, reset_tail_us;
  logic [RW-1:0] write_one_low_us, write_zero_low_us, read_low_us;
  logic [RW-1:0] read_sample_us, slot_us;

  // sequencer state
  owm_pkg::phase_t phase, phase_next;
  owm_pkg::cmd_t   op_kind, op_kind_next;
  logic [CW-1:0]   us_count, us_count_next;
  logic [2:0]      bit_index, bit_index_next;
  logic [7:0]      shift_reg, shift_reg_next;
  logic            presence_flag, presence_flag_next;
  logic [7:0]      read_result, read_result_next;

  // working values after a possible command start
  logic            start, busy_cmd;
  owm_pkg::phase_t phase_s;
  owm_pkg::cmd_t   op_s;
  logic [CW-1:0]   count_s, count_inc;
  logic [2:0]      bit_s;
  logic [7:0]      shift_s;
  logic [RW-1:0]   low_len, high_raw, high_len, sample_len;
  logic            done;
  owm_pkg::out_t   result;
  logic            in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_us      <= owm_pkg::DEF_RESET_LOW;
      presence_wait_us  <= owm_pkg::DEF_PRESENCE_WAIT;
      reset_tail_us     <= owm_pkg::DEF_RESET_TAIL;
      write_one_low_us  <= owm_pkg::DEF_WRITE_ONE_LOW;
      write_zero_low_us <= owm_pkg::DEF_WRITE_ZERO_LOW;
      read_low_us       <= owm_pkg::DEF_READ_LOW;
      read_sample_us    <= owm_pkg::DEF_READ_SAMPLE;
      slot_us           <= owm_pkg::DEF_SLOT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        owm_pkg::REG_RESET_LOW:      reset_low_us      <= cfg_data;
        owm_pkg::REG_PRESENCE_WAIT:  presence_wait_us  <= cfg_data;
        owm_pkg::REG_RESET_TAIL:     reset_tail_us     <= cfg_data;
        owm_pkg::REG_WRITE_ONE_LOW:  write_one_low_us  <= cfg_data;
        owm_pkg::REG_WRITE_ZERO_LOW: write_zero_low_us <= cfg_data;
        owm_pkg::REG_READ_LOW:       read_low_us       <= cfg_data;
        owm_pkg::REG_READ_SAMPLE:    read_sample_us    <= cfg_data;
        owm_pkg::REG_SLOT:           slot_us           <= cfg_data;
        default: ;
      endcase
    end
  end

  // command start or rejection
  assign start    = (in_data.cmd != owm_pkg::CMD_TICK) && (phase == owm_pkg::PH_IDLE);
  assign busy_cmd = (in_data.cmd != owm_pkg::CMD_TICK) && (phase != owm_pkg::PH_IDLE);

  always_comb begin
    if (start) begin
      phase_s = (in_data.cmd == owm_pkg::CMD_RESET) ? owm_pkg::PH_RST_LOW
                                                     : owm_pkg::PH_SLOT_LOW;
      op_s    = in_data.cmd;
      count_s = '0;
      bit_s   = '0;
      shift_s = (in_data.cmd == owm_pkg::CMD_WRITE) ? in_data.wr_byte : 8'h00;
    end else begin
      phase_s = phase;
      op_s    = op_kind;
      count_s = us_count;
      bit_s   = bit_index;
      shift_s = shift_reg;
    end
  end

  assign count_inc = count_s + CW'(1);

  // slot lengths for the current bit
  assign sample_len = owm_pkg::at_least_one(read_sample_us);
  assign low_len = (op_s == owm_pkg::CMD_WRITE)
                 ? owm_pkg::at_least_one(shift_s[0] ? write_one_low_us : write_zero_low_us)
                 : owm_pkg::at_least_one(read_low_us);
  assign high_raw = (slot_us > low_len) ? (slot_us - low_len) : RW'(1);
  assign high_len = ((op_s == owm_pkg::CMD_READ) && (high_raw < sample_len))
                  ? sample_len : high_raw;

  // one microsecond of the sequencer
  always_comb begin
    phase_next         = phase_s;
    op_kind_next       = op_s;
    us_count_next      = count_s;
    bit_index_next     = bit_s;
    shift_reg_next     = shift_s;
    presence_flag_next = presence_flag;
    read_result_next   = read_result;
    done               = 1'b0;
    if (phase_s != owm_pkg::PH_IDLE) begin
      us_count_next = count_inc;
    end
    case (phase_s)
      owm_pkg::PH_IDLE: ;
      owm_pkg::PH_RST_LOW: begin
        if (count_inc >= CW'(owm_pkg::at_least_one(reset_low_us))) begin
          phase_next    = owm_pkg::PH_RST_WAIT;
          us_count_next = '0;
        end
      end
      owm_pkg::PH_RST_WAIT: begin
        if (count_inc >= CW'(owm_pkg::at_least_one(presence_wait_us))) begin
          presence_flag_next = !in_data.line_in;
          if (reset_tail_us == '0) begin
            phase_next     = owm_pkg::PH_IDLE;
            us_count_next  = '0;
            bit_index_next = '0;
            done           = 1'b1;
          end else begin
            phase_next    = owm_pkg::PH_RST_TAIL;
            us_count_next = '0;
          end
        end
      end
      owm_pkg::PH_RST_TAIL: begin
        if (count_inc >= CW'(reset_tail_us)) begin
          phase_next     = owm_pkg::PH_IDLE;
          us_count_next  = '0;
          bit_index_next = '0;
          done           = 1'b1;
        end
      end
      owm_pkg::PH_SLOT_LOW: begin
        if (count_inc >= CW'(low_len)) begin
          phase_next    = owm_pkg::PH_SLOT_HIGH;
          us_count_next = '0;
        end
      end
      owm_pkg::PH_SLOT_HIGH: begin
        // read sample enters at the top and shifts right
        if ((op_s == owm_pkg::CMD_READ) && (count_inc == CW'(sample_len))) begin
          shift_reg_next = {in_data.line_in, shift_s[7:1]};
        end
        if (count_inc >= CW'(high_len)) begin
          if (op_s == owm_pkg::CMD_WRITE) begin
            shift_reg_next = {1'b0, shift_s[7:1]};
          end
          if (bit_s == 3'd7) begin
            if (op_s == owm_pkg::CMD_READ) begin
              read_result_next = shift_reg_next;
            end
            phase_next     = owm_pkg::PH_IDLE;
            us_count_next  = '0;
            bit_index_next = '0;
            done           = 1'b1;
          end else begin
            bit_index_next = bit_s + 3'd1;
            phase_next     = owm_pkg::PH_SLOT_LOW;
            us_count_next  = '0;
          end
        end
      end
      default: begin
        phase_next    = owm_pkg::PH_IDLE;
        us_count_next = '0;
      end
    endcase
  end

  // result word
  always_comb begin
    result.drive_low = (phase_s == owm_pkg::PH_RST_LOW) || (phase_s == owm_pkg::PH_SLOT_LOW);
    result.busy_res  = (phase_s != owm_pkg::PH_IDLE);
    result.done_res  = done;
    result.presence  = presence_flag_next;
    result.rd_byte   = read_result_next;
    result.rejected  = busy_cmd;
  end

  // sequencer state, updated once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= owm_pkg::PH_IDLE;
      op_kind       <= owm_pkg::CMD_TICK;
      us_count      <= '0;
      bit_index     <= '0;
      shift_reg     <= '0;
      presence_flag <= 1'b0;
      read_result   <= '0;
    end else if (in_fire) begin
      phase         <= phase_next;
      op_kind       <= op_kind_next;
      us_count      <= us_count_next;
      bit_index     <= bit_index_next;
      shift_reg     <= shift_reg_next;
      presence_flag <= presence_flag_next;
      read_result   <= read_result_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // idle sequencer holds cleared counters
  assert property (@(posedge clk) disable iff (rst)
    (phase == owm_pkg::PH_IDLE) |-> (us_count == '0 && bit_index == '0))
    else $error("idle phase with nonzero counters");

  // a completing word is always a busy word
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> out_data.busy_res)
    else $error("done without busy");

  // a command is rejected only while another one runs
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.rejected) |-> out_data.busy_res)
    else $error("rejected while idle");

  // the bus is pulled low only during a command
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.drive_low) |-> out_data.busy_res)
    else $error("drive low while idle");

  // an empty output register never blocks input
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");
`endif

endmodule

/* tb/one_wire_bus_master_checker.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master_checker
// Watches the input, result and configuration channels of the 1-Wire bus
// master, predicts the status word of every accepted microsecond from its own
// copy of the sequencer and timing registers, and compares each result word
// field by field against the oldest prediction. Failures are counted.
// ----------------------------------------------------------------------------
module one_wire_bus_master_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  owm_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  owm_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::REG_W-1:0]     cfg_data,
  output int                            failures,
  output int                            pending,
  output bit                            bus_idle
);
  import owm_pkg::*;

  // predicted sequencer state
  phase_t           seq_phase;
  cmd_t             seq_op;
  logic [CNT_W-1:0] us_cnt;
  logic [2:0]       slot_bit;
  logic [7:0]       shifter;
  logic             saw_presence;
  logic [7:0]       last_read;
  logic [REG_W-1:0] timing [2 ** CFG_IDX_W];

  // status words still owed by the block
  out_t bus_status_due[$];
  out_t want_word;
  out_t pred_word;

  function automatic logic [REG_W-1:0] one_min(input logic [REG_W-1:0] v);
    return (v == '0) ? REG_W'(1) : v;
  endfunction

  // low part of the current slot
  function automatic logic [REG_W-1:0] low_pulse_len();
    if (seq_op == CMD_WRITE)
      return one_min(shifter[0] ? timing[REG_WRITE_ONE_LOW] : timing[REG_WRITE_ZERO_LOW]);
    return one_min(timing[REG_READ_LOW]);
  endfunction

  // released part of the current slot, never ending before the read sample
  function automatic logic [REG_W-1:0] release_len();
    logic [REG_W-1:0] lo;
    logic [REG_W-1:0] hi;
    lo = low_pulse_len();
    hi = (timing[REG_SLOT] > lo) ? timing[REG_SLOT] - lo : REG_W'(1);
    if (seq_op == CMD_READ && hi < one_min(timing[REG_READ_SAMPLE]))
      hi = one_min(timing[REG_READ_SAMPLE]);
    return hi;
  endfunction

  task automatic close_command();
    seq_phase = PH_IDLE;
    us_cnt    = '0;
    slot_bit  = '0;
  endtask

  // one microsecond of bus time
  task automatic step_bus_microsecond(input in_t w, output out_t r);
    r = '0;
    if (w.cmd != CMD_TICK) begin
      if (seq_phase == PH_IDLE) begin
        seq_op   = w.cmd;
        us_cnt   = '0;
        slot_bit = '0;
        if (w.cmd == CMD_RESET) begin
          seq_phase = PH_RST_LOW;
        end else begin
          shifter   = (w.cmd == CMD_WRITE) ? w.wr_byte : 8'h00;
          seq_phase = PH_SLOT_LOW;
        end
      end else begin
        r.rejected = 1'b1;
      end
    end
    if (seq_phase != PH_IDLE) begin
      r.busy_res  = 1'b1;
      r.drive_low = (seq_phase == PH_RST_LOW) || (seq_phase == PH_SLOT_LOW);
      us_cnt      = us_cnt + CNT_W'(1);
      case (seq_phase)
        PH_RST_LOW: begin
          if (us_cnt >= one_min(timing[REG_RESET_LOW])) begin
            seq_phase = PH_RST_WAIT;
            us_cnt    = '0;
          end
        end
        PH_RST_WAIT: begin
          if (us_cnt >= one_min(timing[REG_PRESENCE_WAIT])) begin
            saw_presence = ~w.line_in;
            if (timing[REG_RESET_TAIL] == '0) begin
              close_command();
              r.done_res = 1'b1;
            end else begin
              seq_phase = PH_RST_TAIL;
              us_cnt    = '0;
            end
          end
        end
        PH_RST_TAIL: begin
          if (us_cnt >= timing[REG_RESET_TAIL]) begin
            close_command();
            r.done_res = 1'b1;
          end
        end
        PH_SLOT_LOW: begin
          if (us_cnt >= low_pulse_len()) begin
            seq_phase = PH_SLOT_HIGH;
            us_cnt    = '0;
          end
        end
        PH_SLOT_HIGH: begin
          // read bit enters at the top and moves right
          if (seq_op == CMD_READ && us_cnt == one_min(timing[REG_READ_SAMPLE]))
            shifter = {w.line_in, shifter[7:1]};
          if (us_cnt >= release_len()) begin
            if (seq_op == CMD_WRITE)
              shifter = shifter >> 1;
            if (slot_bit == 3'd7) begin
              if (seq_op == CMD_READ)
                last_read = shifter;
              close_command();
              r.done_res = 1'b1;
            end else begin
              slot_bit  = slot_bit + 3'd1;
              seq_phase = PH_SLOT_LOW;
              us_cnt    = '0;
            end
          end
        end
        default: begin
          seq_phase = PH_IDLE;
          us_cnt    = '0;
        end
      endcase
    end
    r.presence = saw_presence;
    r.rd_byte  = last_read;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      failures = failures + 1;
      if (failures <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // compare results, predict accepted words, track configuration
  always @(posedge clk) begin
    if (rst) begin
      timing[REG_RESET_LOW]      = DEF_RESET_LOW;
      timing[REG_PRESENCE_WAIT]  = DEF_PRESENCE_WAIT;
      timing[REG_RESET_TAIL]     = DEF_RESET_TAIL;
      timing[REG_WRITE_ONE_LOW]  = DEF_WRITE_ONE_LOW;
      timing[REG_WRITE_ZERO_LOW] = DEF_WRITE_ZERO_LOW;
      timing[REG_READ_LOW]       = DEF_READ_LOW;
      timing[REG_READ_SAMPLE]    = DEF_READ_SAMPLE;
      timing[REG_SLOT]           = DEF_SLOT;
      seq_phase    = PH_IDLE;
      seq_op       = CMD_TICK;
      us_cnt       = '0;
      slot_bit     = '0;
      shifter      = '0;
      saw_presence = 1'b0;
      last_read    = '0;
      failures     = 0;
      bus_status_due.delete();
      pending  <= 0;
      bus_idle <= 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (bus_status_due.size() == 0) begin
          failures = failures + 1;
          if (failures <= 10)
            $display("%0t: result word %h with nothing expected", $time, out_data);
        end else begin
          want_word = bus_status_due.pop_front();
          check_field("drive_low", 8'(want_word.drive_low), 8'(out_data.drive_low));
          check_field("busy_res", 8'(want_word.busy_res), 8'(out_data.busy_res));
          check_field("done_res", 8'(want_word.done_res), 8'(out_data.done_res));
          check_field("presence", 8'(want_word.presence), 8'(out_data.presence));
          check_field("rd_byte", want_word.rd_byte, out_data.rd_byte);
          check_field("rejected", 8'(want_word.rejected), 8'(out_data.rejected));
        end
      end
      // a word taken at this edge still sees the old timing
      if (in_valid && in_ready) begin
        step_bus_microsecond(in_data, pred_word);
        bus_status_due.push_back(pred_word);
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        timing[cfg_index] = cfg_data;
      pending  <= bus_status_due.size();
      bus_idle <= (seq_phase == PH_IDLE);
    end
  end

endmodule

/* tb/one_wire_bus_master_test.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master_test
// Stimulus for the 1-Wire bus master: power-up timing, minimum and maximum
// timing extremes with directed commands, then random command traffic under
// several timing sets with random gaps and stalls on both channels. Checking
// is done by the checker instance beside the block.
// ----------------------------------------------------------------------------
module one_wire_bus_master_test;
  import owm_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_TICKS = 8;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_WORDS = 2000;
  localparam int RANDOM_SETS  = 6;
  localparam logic [REG_W-1:0] REG_MAX = '1;

  bit                   clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  int               failures;
  int               pending;
  bit               bus_idle;
  int               cycles = 0;
  int               send_gap_pct = 0;
  int               take_gap_pct = 0;
  bit               hold_request = 1'b0;
  logic [REG_W-1:0] plan [2 ** CFG_IDX_W];

  one_wire_bus_master DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  one_wire_bus_master_checker checker_inst (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending),
    .bus_idle  (bus_idle)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : result_taker
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  function automatic in_t random_word();
    in_t w;
    w.cmd     = ($urandom_range(5) == 0) ? cmd_t'($urandom_range(3, 1)) : CMD_TICK;
    w.wr_byte = 8'($urandom);
    w.line_in = 1'($urandom);
    return w;
  endfunction

  // offer one word, return at the edge that takes it
  task automatic send_word(input in_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_cmd(input cmd_t c, input logic [7:0] b, input logic line);
    in_t w;
    w.cmd     = c;
    w.wr_byte = b;
    w.line_in = line;
    send_word(w);
  endtask

  // ticks until the running command is over, then release the channel
  task automatic drain_bus();
    in_t w;
    do begin
      w     = random_word();
      w.cmd = CMD_TICK;
      send_word(w);
    end while (!bus_idle);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // write a timing set once every result is in, plus one unused index
  task automatic load_plan();
    wait (pending == 0);
    repeat (SETTLE_TICKS) @(negedge clk);
    for (int i = 0; i < NUM_REGS; i++)
      put_reg(CFG_IDX_W'(i), plan[CFG_IDX_W'(i)]);
    put_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(2 ** CFG_IDX_W - NUM_REGS - 1)),
            REG_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int take_pct);
    send_gap_pct = send_pct;
    take_gap_pct = take_pct;
  endtask

  initial begin : stimulus
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    set_idling(17, 48);
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // power-up timing: one read under the reset values
    send_cmd(CMD_READ, 8'h00, 1'b1);
    drain_bus();

    // shortest timing: tail of zero, read sample of zero, two-microsecond slots
    plan[REG_RESET_LOW]      = 10'd1;
    plan[REG_PRESENCE_WAIT]  = 10'd1;
    plan[REG_RESET_TAIL]     = 10'd0;
    plan[REG_WRITE_ONE_LOW]  = 10'd1;
    plan[REG_WRITE_ZERO_LOW] = 10'd1;
    plan[REG_READ_LOW]       = 10'd1;
    plan[REG_READ_SAMPLE]    = 10'd0;
    plan[REG_SLOT]           = 10'd2;
    load_plan();

    // presence seen, command on the completing microsecond, presence missed
    send_cmd(CMD_RESET, 8'hFF, 1'b1);
    send_cmd(CMD_RESET, 8'h00, 1'b0);
    send_cmd(CMD_RESET, 8'h00, 1'b0);
    send_cmd(CMD_TICK, 8'hFF, 1'b1);
    // writes of all ones and all zeros, commands while busy
    send_cmd(CMD_WRITE, 8'hFF, 1'b0);
    send_cmd(CMD_WRITE, 8'h00, 1'b1);
    send_cmd(CMD_READ, 8'hFF, 1'b1);
    send_cmd(CMD_RESET, 8'h00, 1'b0);
    drain_bus();
    send_cmd(CMD_WRITE, 8'h00, 1'b1);
    drain_bus();
    // reads of a high and a low line
    send_cmd(CMD_READ, 8'h00, 1'b1);
    for (int i = 0; i < 16; i++)
      send_cmd(CMD_TICK, 8'h00, 1'b1);
    send_cmd(CMD_READ, 8'hFF, 1'b0);
    for (int i = 0; i < 16; i++)
      send_cmd(CMD_TICK, 8'hFF, 1'b0);
    drain_bus();

    // longest timing: every register at its top value
    for (int i = 0; i < NUM_REGS; i++)
      plan[CFG_IDX_W'(i)] = REG_MAX;
    load_plan();
    send_cmd(CMD_RESET, 8'h5A, 1'b0);
    drain_bus();

    // random traffic under several timing sets
    for (int p = 0; p < RANDOM_SETS; p++) begin
      case (p / 2)
        0:       set_idling(17, 48);
        1:       set_idling(48, 17);
        default: set_idling(0, 0);
      endcase
      if (p == 0) begin
        plan[REG_RESET_LOW]      = DEF_RESET_LOW;
        plan[REG_PRESENCE_WAIT]  = DEF_PRESENCE_WAIT;
        plan[REG_RESET_TAIL]     = DEF_RESET_TAIL;
        plan[REG_WRITE_ONE_LOW]  = DEF_WRITE_ONE_LOW;
        plan[REG_WRITE_ZERO_LOW] = DEF_WRITE_ZERO_LOW;
        plan[REG_READ_LOW]       = DEF_READ_LOW;
        plan[REG_READ_SAMPLE]    = DEF_READ_SAMPLE;
        plan[REG_SLOT]           = DEF_SLOT;
      end else begin
        plan[REG_RESET_LOW]      = REG_W'($urandom_range(30, 1));
        plan[REG_PRESENCE_WAIT]  = REG_W'($urandom_range(30, 1));
        plan[REG_RESET_TAIL]     = REG_W'($urandom_range(30, 0));
        plan[REG_WRITE_ONE_LOW]  = REG_W'($urandom_range(8, 1));
        plan[REG_WRITE_ZERO_LOW] = REG_W'($urandom_range(16, 1));
        plan[REG_READ_LOW]       = REG_W'($urandom_range(8, 1));
        plan[REG_READ_SAMPLE]    = REG_W'($urandom_range(12, 0));
        plan[REG_SLOT]           = REG_W'($urandom_range(24, 2));
      end
      load_plan();
      // result side stops for a while so the block backs up
      if (p == 4)
        hold_request = 1'b1;
      for (int n = 0; n < RANDOM_WORDS / RANDOM_SETS; n++)
        send_word(random_word());
      drain_bus();
    end

    wait (pending == 0);
    repeat (SETTLE_TICKS) @(negedge clk);
    if (failures == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
